### rtl/lobu_pkg.sv
package lobu_pkg;

   localparam int MAX_ORDERS = 1024;
   localparam int MAX_LEVELS = 256;
   localparam int ORD_AW = $clog2(MAX_ORDERS);
   localparam int LVL_AW = $clog2(MAX_LEVELS);
   localparam int CLR_AW = (ORD_AW > LVL_AW) ? ORD_AW : LVL_AW;
   localparam int CLR_N = (MAX_ORDERS > MAX_LEVELS) ? MAX_ORDERS : MAX_LEVELS;

   localparam logic [2:0] FN_ADD     = 3'd1;
   localparam logic [2:0] FN_CANCEL  = 3'd2;
   localparam logic [2:0] FN_DELETE  = 3'd3;
   localparam logic [2:0] FN_EXECUTE = 3'd4;

   localparam logic [1:0] KIND_IGNORE = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REDUCE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_USED  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   localparam logic [39:0] SUM_MAX   = 40'hFF_FFFF_FFFF;
   localparam logic [10:0] COUNT_MAX = 11'd2047;
   localparam logic [23:0] QTY_ALL   = 24'hFF_FFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic        is_exec;
      logic [31:0] order_ref;
      logic [23:0] qty;
      logic [30:0] price;
      logic        buy;
   } job_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        side_buy;
      logic [30:0] level_price;
      logic [23:0] order_left;
      logic [39:0] level_total;
      logic [10:0] level_orders;
      logic        level_gone;
      logic        trade_valid;
      logic [23:0] trade_qty;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  slot;
      logic [31:0] key;
      logic        buy;
      logic [30:0] price;
      logic [23:0] rem;
   } ord_type;

   typedef struct packed {
      logic [1:0]  slot;
      logic        buy;
      logic [30:0] price;
      logic [39:0] sum;
      logic [10:0] count;
   } lvl_type;

   function automatic logic [ORD_AW-1:0] hash_order(logic [31:0] key);
      logic [ORD_AW-1:0] h;
      h = '0;
      for (int i = 0; i < 32; i++) begin
         h[i % ORD_AW] = h[i % ORD_AW] ^ key[i];
      end
      if ({1'b0, h} >= (ORD_AW+1)'(MAX_ORDERS)) begin
         h = ORD_AW'({1'b0, h} - (ORD_AW+1)'(MAX_ORDERS));
      end
      return h;
   endfunction

   function automatic logic [LVL_AW-1:0] hash_level(logic [31:0] key);
      logic [LVL_AW-1:0] h;
      h = '0;
      for (int i = 0; i < 32; i++) begin
         h[i % LVL_AW] = h[i % LVL_AW] ^ key[i];
      end
      if ({1'b0, h} >= (LVL_AW+1)'(MAX_LEVELS)) begin
         h = LVL_AW'({1'b0, h} - (LVL_AW+1)'(MAX_LEVELS));
      end
      return h;
   endfunction

endpackage

### rtl/lobu_front.sv
module lobu_front
   import lobu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_order_ref,
   input  logic [23:0] req_quantity,
   input  logic [30:0] req_price,
   input  logic        req_is_buy,
   output logic        job_valid,
   input  logic        job_ready,
   output job_type     job
);

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;

   assign req_ready = !valid_ff || job_ready;
   assign job_valid = valid_ff;
   assign job = job_ff;

   // classify the event; delete takes the whole remaining quantity
   always_comb begin
      job_in = job_ff;
      valid_in = valid_ff;
      if (job_ready) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         job_in.order_ref = req_order_ref;
         job_in.price = req_price;
         job_in.buy = req_is_buy;
         job_in.qty = req_quantity;
         job_in.is_exec = 1'b0;
         case (req_func)
            FN_ADD: begin
               job_in.kind = KIND_ADD;
            end
            FN_CANCEL: begin
               job_in.kind = KIND_REDUCE;
            end
            FN_DELETE: begin
               job_in.kind = KIND_REDUCE;
               job_in.qty = QTY_ALL;
            end
            FN_EXECUTE: begin
               job_in.kind = KIND_REDUCE;
               job_in.is_exec = 1'b1;
            end
            default: begin
               job_in.kind = KIND_IGNORE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

### rtl/lobu_queue.sv
module lobu_queue
   import lobu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_job = entry_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

### rtl/lobu_back.sv
module lobu_back
   import lobu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_OPROBE  = 3'd2;
   localparam logic [2:0] S_LSTART  = 3'd3;
   localparam logic [2:0] S_LPROBE  = 3'd4;
   localparam logic [2:0] S_COMPUTE = 3'd5;

   ord_type order_mem [MAX_ORDERS];
   lvl_type level_mem [MAX_LEVELS];

   logic [2:0]        state_ff, state_in;
   logic [CLR_AW-1:0] clr_ff, clr_in;
   logic [CLR_AW-1:0] n_ff, n_in;
   job_type           job_ff, job_in;

   logic [ORD_AW-1:0] o_cur_ff, o_cur_in, o_slot_ff, o_slot_in, o_free_ff, o_free_in;
   logic              o_hit_ff, o_hit_in, o_ffound_ff, o_ffound_in;
   ord_type           o_ent_ff, o_ent_in;
   logic [LVL_AW-1:0] l_cur_ff, l_cur_in, l_slot_ff, l_slot_in, l_free_ff, l_free_in;
   logic              l_hit_ff, l_hit_in, l_ffound_ff, l_ffound_in;
   lvl_type           l_ent_ff, l_ent_in;
   logic [31:0]       l_key_ff, l_key_in;

   ord_type           o_rdata_ff;
   lvl_type           l_rdata_ff;
   logic [ORD_AW-1:0] o_raddr, o_waddr, o_next;
   logic [LVL_AW-1:0] l_raddr, l_waddr, l_next;
   logic              o_we, l_we;
   ord_type           o_wdata;
   lvl_type           l_wdata;

   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              can_put;
   logic              o_match, o_free_here, o_last, o_done;
   logic              l_match, l_free_here, l_last, l_done;
   logic [31:0]       l_key_now;
   logic              clr_last;

   // compute path values
   logic [39:0] base_sum, add_sum, red_sum;
   logic [40:0] sum_wide;
   logic [10:0] base_cnt, add_cnt, red_cnt;
   logic [23:0] sub_amt;
   logic        full_del;

   assign job_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
   assign can_put = !rsp_valid_ff || rsp_ready;

   assign o_next = (o_cur_ff == ORD_AW'(MAX_ORDERS - 1)) ? '0 : o_cur_ff + 1'b1;
   assign l_next = (l_cur_ff == LVL_AW'(MAX_LEVELS - 1)) ? '0 : l_cur_ff + 1'b1;
   assign clr_last = (clr_ff == CLR_AW'(CLR_N - 1));

   assign o_match = (o_rdata_ff.slot == SLOT_USED) && (o_rdata_ff.key == job_ff.order_ref);
   assign o_free_here = (o_rdata_ff.slot != SLOT_USED);
   assign o_last = (n_ff == CLR_AW'(MAX_ORDERS - 1));
   assign o_done = o_match || (o_rdata_ff.slot == SLOT_EMPTY) || o_last;

   assign l_match = (l_rdata_ff.slot == SLOT_USED) && (l_rdata_ff.buy == l_key_ff[31])
                    && (l_rdata_ff.price == l_key_ff[30:0]);
   assign l_free_here = (l_rdata_ff.slot != SLOT_USED);
   assign l_last = (n_ff == CLR_AW'(MAX_LEVELS - 1));
   assign l_done = l_match || (l_rdata_ff.slot == SLOT_EMPTY) || l_last;

   assign l_key_now = (job_ff.kind == KIND_ADD) ? {job_ff.buy, job_ff.price}
                                                : {o_ent_ff.buy, o_ent_ff.price};

   // level arithmetic
   always_comb begin
      base_sum = l_hit_ff ? l_ent_ff.sum : '0;
      base_cnt = l_hit_ff ? l_ent_ff.count : '0;
      sum_wide = {1'b0, base_sum} + 41'(job_ff.qty);
      add_sum = sum_wide[40] ? SUM_MAX : sum_wide[39:0];
      add_cnt = (base_cnt < COUNT_MAX) ? base_cnt + 11'd1 : base_cnt;
      full_del = (o_ent_ff.rem <= job_ff.qty);
      sub_amt = full_del ? o_ent_ff.rem : job_ff.qty;
      red_sum = (l_ent_ff.sum > 40'(sub_amt)) ? l_ent_ff.sum - 40'(sub_amt) : '0;
      if (full_del) begin
         red_cnt = (l_ent_ff.count != 11'd0) ? l_ent_ff.count - 11'd1 : 11'd0;
      end else begin
         red_cnt = l_ent_ff.count;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      n_in = n_ff;
      job_in = job_ff;
      o_cur_in = o_cur_ff;
      o_slot_in = o_slot_ff;
      o_free_in = o_free_ff;
      o_hit_in = o_hit_ff;
      o_ffound_in = o_ffound_ff;
      o_ent_in = o_ent_ff;
      l_cur_in = l_cur_ff;
      l_slot_in = l_slot_ff;
      l_free_in = l_free_ff;
      l_hit_in = l_hit_ff;
      l_ffound_in = l_ffound_ff;
      l_ent_in = l_ent_ff;
      l_key_in = l_key_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_raddr = o_next;
      l_raddr = l_next;
      o_we = 1'b0;
      o_waddr = o_slot_ff;
      o_wdata = o_ent_ff;
      l_we = 1'b0;
      l_waddr = l_slot_ff;
      l_wdata = l_ent_ff;

      case (state_ff)
         S_CLEAR: begin
            o_we = ({1'b0, clr_ff} < (CLR_AW+1)'(MAX_ORDERS));
            o_waddr = clr_ff[ORD_AW-1:0];
            o_wdata = '0;
            o_wdata.slot = SLOT_EMPTY;
            l_we = ({1'b0, clr_ff} < (CLR_AW+1)'(MAX_LEVELS));
            l_waddr = clr_ff[LVL_AW-1:0];
            l_wdata = '0;
            l_wdata.slot = SLOT_EMPTY;
            clr_in = clr_ff + 1'b1;
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            o_raddr = hash_order(job.order_ref);
            if (job_valid) begin
               job_in = job;
               o_cur_in = hash_order(job.order_ref);
               n_in = '0;
               o_hit_in = 1'b0;
               o_ffound_in = 1'b0;
               state_in = (job.kind == KIND_IGNORE) ? S_COMPUTE : S_OPROBE;
            end
         end
         S_OPROBE: begin
            if (o_match) begin
               o_hit_in = 1'b1;
               o_slot_in = o_cur_ff;
               o_ent_in = o_rdata_ff;
            end
            if (o_free_here && !o_ffound_ff) begin
               o_ffound_in = 1'b1;
               o_free_in = o_cur_ff;
            end
            if (o_done) begin
               if ((job_ff.kind == KIND_ADD) || o_match) begin
                  state_in = S_LSTART;
               end else begin
                  state_in = S_COMPUTE;
               end
            end else begin
               o_cur_in = o_next;
               n_in = n_ff + 1'b1;
            end
         end
         S_LSTART: begin
            l_raddr = hash_level(l_key_now);
            l_cur_in = hash_level(l_key_now);
            l_key_in = l_key_now;
            n_in = '0;
            l_hit_in = 1'b0;
            l_ffound_in = 1'b0;
            state_in = S_LPROBE;
         end
         S_LPROBE: begin
            if (l_match) begin
               l_hit_in = 1'b1;
               l_slot_in = l_cur_ff;
               l_ent_in = l_rdata_ff;
            end
            if (l_free_here && !l_ffound_ff) begin
               l_ffound_in = 1'b1;
               l_free_in = l_cur_ff;
            end
            if (l_done) begin
               state_in = S_COMPUTE;
            end else begin
               l_cur_in = l_next;
               n_in = n_ff + 1'b1;
            end
         end
         S_COMPUTE: begin
            if (can_put) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               if (job_ff.kind == KIND_IGNORE) begin
                  rsp_in.status = ST_IGNORED;
               end else if (job_ff.kind == KIND_ADD) begin
                  rsp_in.side_buy = job_ff.buy;
                  rsp_in.level_price = job_ff.price;
                  if (!(o_hit_ff || o_ffound_ff) || !(l_hit_ff || l_ffound_ff)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     rsp_in.status = ST_OK;
                     rsp_in.order_left = job_ff.qty;
                     rsp_in.level_total = add_sum;
                     rsp_in.level_orders = add_cnt;
                     o_we = 1'b1;
                     o_waddr = o_hit_ff ? o_slot_ff : o_free_ff;
                     o_wdata.slot = SLOT_USED;
                     o_wdata.key = job_ff.order_ref;
                     o_wdata.buy = job_ff.buy;
                     o_wdata.price = job_ff.price;
                     o_wdata.rem = job_ff.qty;
                     l_we = 1'b1;
                     l_waddr = l_hit_ff ? l_slot_ff : l_free_ff;
                     l_wdata.slot = SLOT_USED;
                     l_wdata.buy = job_ff.buy;
                     l_wdata.price = job_ff.price;
                     l_wdata.sum = add_sum;
                     l_wdata.count = add_cnt;
                  end
               end else if (!o_hit_ff) begin
                  rsp_in.status = ST_UNKNOWN;
               end else begin
                  rsp_in.status = ST_OK;
                  rsp_in.side_buy = o_ent_ff.buy;
                  rsp_in.level_price = o_ent_ff.price;
                  rsp_in.trade_valid = job_ff.is_exec;
                  rsp_in.trade_qty = job_ff.is_exec ? job_ff.qty : '0;
                  o_we = 1'b1;
                  o_waddr = o_slot_ff;
                  if (full_del) begin
                     o_wdata.slot = SLOT_TOMB;
                     rsp_in.order_left = '0;
                  end else begin
                     o_wdata.rem = o_ent_ff.rem - job_ff.qty;
                     rsp_in.order_left = o_ent_ff.rem - job_ff.qty;
                  end
                  if (l_hit_ff) begin
                     l_we = 1'b1;
                     l_waddr = l_slot_ff;
                     l_wdata.sum = red_sum;
                     l_wdata.count = red_cnt;
                     if (red_cnt == 11'd0) begin
                        l_wdata.slot = SLOT_TOMB;
                        rsp_in.level_gone = 1'b1;
                     end else begin
                        rsp_in.level_total = red_sum;
                        rsp_in.level_orders = red_cnt;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in;
      job_ff <= job_in;
      o_cur_ff <= o_cur_in;
      o_slot_ff <= o_slot_in;
      o_free_ff <= o_free_in;
      o_hit_ff <= o_hit_in;
      o_ffound_ff <= o_ffound_in;
      o_ent_ff <= o_ent_in;
      l_cur_ff <= l_cur_in;
      l_slot_ff <= l_slot_in;
      l_free_ff <= l_free_in;
      l_hit_ff <= l_hit_in;
      l_ffound_ff <= l_ffound_in;
      l_ent_ff <= l_ent_in;
      l_key_ff <= l_key_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (o_we) begin
         order_mem[o_waddr] <= o_wdata;
      end
      o_rdata_ff <= order_mem[o_raddr];
   end

   always_ff @(posedge clock) begin
      if (l_we) begin
         level_mem[l_waddr] <= l_wdata;
      end
      l_rdata_ff <= level_mem[l_raddr];
   end

endmodule

### rtl/limit_order_book_update_unit.sv
// path: the front end registers and classifies the beat, the queue holds it, then
//   the back end probes the order table and the level table, each probe running from
//   one slot up to the table depth, and registers the result; the back end takes a
//   new event only when idle, and each hashed table has a single read port
// reset: synchronous, clears control state, then a sweep marks every table entry
//   empty; the back end takes no event until the sweep is done
module limit_order_book_update_unit
   import lobu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_order_ref,
   input  logic [23:0] req_quantity,
   input  logic [30:0] req_price,
   input  logic        req_is_buy,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_side_buy,
   output logic [30:0] rsp_level_price,
   output logic [23:0] rsp_order_left,
   output logic [39:0] rsp_level_total,
   output logic [10:0] rsp_level_orders,
   output logic        rsp_level_gone,
   output logic        rsp_trade_valid,
   output logic [23:0] rsp_trade_qty
);

   // front end to queue
   logic    fr_valid, fr_ready;
   job_type fr_job;
   // queue to back end
   logic    bk_valid, bk_ready;
   job_type bk_job;
   rsp_type rsp;

   // front: takes the input beat and classifies the event
   lobu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_order_ref (req_order_ref),
      .req_quantity  (req_quantity),
      .req_price     (req_price),
      .req_is_buy    (req_is_buy),
      .job_valid     (fr_valid),
      .job_ready     (fr_ready),
      .job           (fr_job)
   );

   // short queue so the front keeps taking beats while the back probes
   lobu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_job    (fr_job),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_job   (bk_job)
   );

   // back: hashed order and level tables, read-modify-write, result register
   lobu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bk_valid),
      .job_ready (bk_ready),
      .job       (bk_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // unpack the result beat onto its ports
   assign rsp_status = rsp.status;
   assign rsp_side_buy = rsp.side_buy;
   assign rsp_level_price = rsp.level_price;
   assign rsp_order_left = rsp.order_left;
   assign rsp_level_total = rsp.level_total;
   assign rsp_level_orders = rsp.level_orders;
   assign rsp_level_gone = rsp.level_gone;
   assign rsp_trade_valid = rsp.trade_valid;
   assign rsp_trade_qty = rsp.trade_qty;

endmodule

### tb/order_book_checker.sv
module order_book_checker
   import lobu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_order_ref,
   input  logic [23:0] req_quantity,
   input  logic [30:0] req_price,
   input  logic        req_is_buy,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_beat,
   output int          mismatches,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic        book_live [MAX_ORDERS];
   logic [31:0] book_id [MAX_ORDERS];
   logic        book_buy [MAX_ORDERS];
   logic [30:0] book_price [MAX_ORDERS];
   logic [23:0] book_left [MAX_ORDERS];
   logic        tier_live [MAX_LEVELS];
   logic        tier_buy [MAX_LEVELS];
   logic [30:0] tier_price [MAX_LEVELS];
   logic [39:0] tier_sum [MAX_LEVELS];
   logic [10:0] tier_count [MAX_LEVELS];

   rsp_type expected_rsps[$];

   assign outstanding = expected_rsps.size();

   function automatic int lookup_order(logic [31:0] id);
      for (int i = 0; i < MAX_ORDERS; i++)
         if (book_live[i] && book_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int lookup_level(logic b, logic [30:0] p);
      for (int i = 0; i < MAX_LEVELS; i++)
         if (tier_live[i] && tier_buy[i] == b && tier_price[i] == p) return i;
      return -1;
   endfunction

   function automatic logic [39:0] floor_sub(logic [39:0] a, logic [39:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   function automatic rsp_type apply_event(logic [2:0] f, logic [31:0] id,
                                          logic [23:0] q, logic [30:0] p, logic b);
      rsp_type r;
      int oi;
      int li;
      logic [23:0] cut;
      r = '0;
      if (f == FN_ADD) begin
         oi = lookup_order(id);
         if (oi < 0)
            for (int i = 0; i < MAX_ORDERS && oi < 0; i++) if (!book_live[i]) oi = i;
         li = lookup_level(b, p);
         if (li < 0)
            for (int i = 0; i < MAX_LEVELS && li < 0; i++) if (!tier_live[i]) li = i;
         r.side_buy = b;
         r.level_price = p;
         if (oi < 0 || li < 0) begin
            r.status = ST_FULL;
            return r;
         end
         if (!tier_live[li]) begin
            tier_live[li] = 1'b1;
            tier_buy[li] = b;
            tier_price[li] = p;
            tier_sum[li] = '0;
            tier_count[li] = '0;
         end
         if (tier_count[li] < COUNT_MAX) tier_count[li]++;
         tier_sum[li] = (SUM_MAX - tier_sum[li] < 40'(q)) ? SUM_MAX : tier_sum[li] + 40'(q);
         book_live[oi] = 1'b1;
         book_id[oi] = id;
         book_buy[oi] = b;
         book_price[oi] = p;
         book_left[oi] = q;
         r.status = ST_OK;
         r.order_left = q;
         r.level_total = tier_sum[li];
         r.level_orders = tier_count[li];
         return r;
      end
      if (f != FN_CANCEL && f != FN_DELETE && f != FN_EXECUTE) begin
         r.status = ST_IGNORED;
         return r;
      end
      oi = lookup_order(id);
      if (oi < 0) begin
         r.status = ST_UNKNOWN;
         return r;
      end
      cut = (f == FN_DELETE) ? QTY_ALL : q;
      if (f == FN_EXECUTE) begin
         r.trade_valid = 1'b1;
         r.trade_qty = q;
      end
      r.status = ST_OK;
      r.side_buy = book_buy[oi];
      r.level_price = book_price[oi];
      li = lookup_level(book_buy[oi], book_price[oi]);
      if (book_left[oi] <= cut) begin
         book_live[oi] = 1'b0;
         if (li >= 0) begin
            if (tier_count[li] > 0) tier_count[li]--;
            tier_sum[li] = floor_sub(tier_sum[li], 40'(book_left[oi]));
            if (tier_count[li] == 0) begin
               tier_live[li] = 1'b0;
               r.level_gone = 1'b1;
            end else begin
               r.level_total = tier_sum[li];
               r.level_orders = tier_count[li];
            end
         end
      end else begin
         book_left[oi] = book_left[oi] - cut;
         r.order_left = book_left[oi];
         if (li >= 0) begin
            tier_sum[li] = floor_sub(tier_sum[li], 40'(cut));
            r.level_total = tier_sum[li];
            r.level_orders = tier_count[li];
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t mismatch %s: expected %0h, got %0h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mismatches = 0;
         expected_rsps.delete();
         for (int i = 0; i < MAX_ORDERS; i++) book_live[i] = 1'b0;
         for (int i = 0; i < MAX_LEVELS; i++) tier_live[i] = 1'b0;
      end else begin
         // retire before predicting, a new beat can never answer in the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               $display("%0t mismatch: result beat with nothing expected", $realtime);
            end else begin
               want = expected_rsps[0];
               expected_rsps.delete(0);
               check_field("status", want.status, rsp_beat.status);
               check_field("side_buy", want.side_buy, rsp_beat.side_buy);
               check_field("level_price", want.level_price, rsp_beat.level_price);
               check_field("order_left", want.order_left, rsp_beat.order_left);
               check_field("level_total", want.level_total, rsp_beat.level_total);
               check_field("level_orders", want.level_orders, rsp_beat.level_orders);
               check_field("level_gone", want.level_gone, rsp_beat.level_gone);
               check_field("trade_valid", want.trade_valid, rsp_beat.trade_valid);
               check_field("trade_qty", want.trade_qty, rsp_beat.trade_qty);
            end
         end
         if (req_valid && req_ready)
            expected_rsps.insert(expected_rsps.size(),
                                 apply_event(req_func, req_order_ref, req_quantity,
                                             req_price, req_is_buy));
      end
   end

endmodule

### tb/testbench.sv
module testbench;
   import lobu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 5000000;
   localparam int DRAIN_CYCLES = 1400;   // worst probe lengths on both tables plus pipeline

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_func;
   logic [31:0] req_order_ref;
   logic [23:0] req_quantity;
   logic [30:0] req_price;
   logic        req_is_buy;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_beat;
   logic        req_taken;
   int          mismatches;
   int          outstanding;
   int          cycles = 0;

   // small pools so that cancels and executes mostly land on live orders
   logic [31:0] id_pool [24];
   logic [30:0] price_pool [6];

   limit_order_book_update_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_order_ref(req_order_ref), .req_quantity(req_quantity),
      .req_price(req_price), .req_is_buy(req_is_buy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_beat.status), .rsp_side_buy(rsp_beat.side_buy),
      .rsp_level_price(rsp_beat.level_price), .rsp_order_left(rsp_beat.order_left),
      .rsp_level_total(rsp_beat.level_total), .rsp_level_orders(rsp_beat.level_orders),
      .rsp_level_gone(rsp_beat.level_gone), .rsp_trade_valid(rsp_beat.trade_valid),
      .rsp_trade_qty(rsp_beat.trade_qty)
   );

   order_book_checker scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_order_ref(req_order_ref), .req_quantity(req_quantity),
      .req_price(req_price), .req_is_buy(req_is_buy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_beat(rsp_beat),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // input beat accepted at the last rising edge, seen by the driver at the falling edge
   always @(posedge clock) req_taken <= req_valid && req_ready && !reset;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side back-pressure, with runs of no stalling
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (cycles % 2000 < 400) rsp_ready <= 1'b1;
      else rsp_ready <= (gap_length() == 0);
   end

   task automatic send_event(logic [2:0] f, logic [31:0] id, logic [23:0] q,
                             logic [30:0] p, logic b);
      int idle;
      idle = (cycles % 3000 < 500) ? 0 : gap_length();
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_order_ref <= id;
      req_quantity <= q;
      req_price <= p;
      req_is_buy <= b;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic random_events(int n);
      logic [2:0]  f;
      logic [31:0] id;
      logic [23:0] q;
      logic [30:0] p;
      int roll;
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) f = FN_ADD;
         else if (roll < 60) f = FN_CANCEL;
         else if (roll < 75) f = FN_EXECUTE;
         else if (roll < 92) f = FN_DELETE;
         else f = 3'($urandom_range(5, 8));   // 5, 6, 7 and 0 (wrap) are not events
         id = ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 23)];
         p = ($urandom_range(0, 5) == 0) ? 31'($urandom()) : price_pool[$urandom_range(0, 5)];
         case ($urandom_range(0, 3))
            0: q = 24'($urandom());
            1: q = 24'($urandom_range(0, 3));
            default: q = 24'($urandom_range(1, 500));
         endcase
         send_event(f, id, q, p, 1'($urandom()));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = '0;
      req_order_ref = '0;
      req_quantity = '0;
      req_price = '0;
      req_is_buy = 1'b0;
      for (int i = 0; i < 24; i++) id_pool[i] = $urandom();
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 0; i < 6; i++) price_pool[i] = 31'($urandom());
      price_pool[0] = '0;
      price_pool[1] = '1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, overwrite, partial and full reductions
      send_event(FN_ADD, 32'h0, 24'h0, 31'h0, 1'b0);
      send_event(FN_ADD, 32'hFFFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF, 1'b1);
      send_event(FN_ADD, 32'h5, 24'd100, 31'h7FFF_FFFF, 1'b1);
      send_event(FN_CANCEL, 32'h5, 24'd30, 31'h0, 1'b0);
      send_event(FN_EXECUTE, 32'h5, 24'd20, 31'h0, 1'b0);
      send_event(FN_EXECUTE, 32'h5, 24'd50, 31'h0, 1'b0);
      send_event(FN_ADD, 32'hFFFF_FFFF, 24'd7, 31'd1234, 1'b0);  // known id moves level
      send_event(FN_CANCEL, 32'hFFFF_FFFF, 24'hFF_FFFF, 31'h0, 1'b1);
      send_event(FN_DELETE, 32'hFFFF_FFFF, 24'h0, 31'h0, 1'b0);  // already gone
      send_event(FN_CANCEL, 32'h0, 24'h0, 31'h0, 1'b0);          // zero left, zero cut
      send_event(FN_EXECUTE, 32'h1234_5678, 24'd1, 31'h0, 1'b0);
      send_event(FN_CANCEL, 32'h1234_5678, 24'd1, 31'h0, 1'b0);
      send_event(3'd0, 32'h1, 24'd1, 31'd1, 1'b1);
      send_event(3'd5, 32'h1, 24'd1, 31'd1, 1'b1);
      send_event(3'd6, 32'h1, 24'd1, 31'd1, 1'b1);
      send_event(3'd7, 32'hFFFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF, 1'b1);
      send_event(FN_ADD, 32'hA, 24'd10, 31'd500, 1'b0);
      send_event(FN_ADD, 32'hB, 24'd15, 31'd500, 1'b0);
      send_event(FN_ADD, 32'hC, 24'd5, 31'd500, 1'b1);           // same price, other side
      send_event(FN_DELETE, 32'hA, 24'd0, 31'h0, 1'b0);
      send_event(FN_EXECUTE, 32'hB, 24'hFF_FFFF, 31'h0, 1'b0);
      send_event(FN_DELETE, 32'hC, 24'd0, 31'h0, 1'b0);

      random_events(300);

      // drain completely before filling the level table
      wait_for_idle();

      // one fresh level per add until the level table runs out
      for (int i = 0; i < 262; i++)
         send_event(FN_ADD, 32'h4000_0000 + i, 24'($urandom()), 31'h1000_0000 + i,
                    1'($urandom()));
      for (int i = 0; i < 262; i++)
         send_event(($urandom_range(0, 1) == 0) ? FN_DELETE : FN_EXECUTE,
                    32'h4000_0000 + i, 24'hFF_FFFF, 31'($urandom()), 1'($urandom()));

      random_events(150);

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/lobu_pkg.sv
rtl/lobu_front.sv
rtl/lobu_queue.sv
rtl/lobu_back.sv
rtl/limit_order_book_update_unit.sv
tb/order_book_checker.sv
tb/testbench.sv
